>>> hw/rtl/svpwm_pkg.sv
// svpwm_pkg: shared constants, tables, types and helpers of the SVPWM duty generator.
// No dependencies; imported by every module of the block.
package svpwm_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int SINE_TABLE_DEPTH = 200;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_IDX_MUL     = 4 * (SINE_TABLE_DEPTH - 1);
    localparam int SQRT_STAGES      = 32;
    localparam int DIV_STAGES       = 16;
    localparam int CORDIC_W         = 28;
    localparam int MOD_LIMIT        = 37814;
    localparam int SQRT3_Q16        = 113512;
    localparam int SINE_SCALE       = 10000;
    localparam int RECIP_SHIFT      = 40;
    localparam logic [26:0] RECIP_SINE = 27'((64'd1 << RECIP_SHIFT) / SINE_SCALE);

    // configuration register indexes
    localparam logic REG_SUPPLY     = 1'b0;
    localparam logic REG_FULL_SCALE = 1'b1;

    typedef logic [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [16:0]    mod_t;

    typedef struct packed {
        logic        simple;   // volt_d was zero
        logic        neg;      // volt_q negative
        logic [15:0] abs_q;
        angle_t      theta;
        angle_t      off;
    } svpwm_side_t;

    localparam angle_t QUARTER_TURN = angle_t'(1 << (ANGLE_BITS - 2));
    localparam angle_t HALF_TURN    = angle_t'(1 << (ANGLE_BITS - 1));

    // quarter-wave sine, scaled by 10000
    localparam logic [13:0] QUARTER_SINE [SINE_TABLE_DEPTH] = '{
        14'd0,14'd79,14'd158,14'd237,14'd316,14'd395,14'd473,14'd552,14'd631,14'd710,
        14'd789,14'd867,14'd946,14'd1024,14'd1103,14'd1181,14'd1260,14'd1338,14'd1416,
        14'd1494,14'd1572,14'd1650,14'd1728,14'd1806,14'd1883,14'd1961,14'd2038,14'd2115,
        14'd2192,14'd2269,14'd2346,14'd2423,14'd2499,14'd2575,14'd2652,14'd2728,14'd2804,
        14'd2879,14'd2955,14'd3030,14'd3105,14'd3180,14'd3255,14'd3329,14'd3404,14'd3478,
        14'd3552,14'd3625,14'd3699,14'd3772,14'd3845,14'd3918,14'd3990,14'd4063,14'd4135,
        14'd4206,14'd4278,14'd4349,14'd4420,14'd4491,14'd4561,14'd4631,14'd4701,14'd4770,
        14'd4840,14'd4909,14'd4977,14'd5046,14'd5113,14'd5181,14'd5249,14'd5316,14'd5382,
        14'd5449,14'd5515,14'd5580,14'd5646,14'd5711,14'd5775,14'd5839,14'd5903,14'd5967,
        14'd6030,14'd6093,14'd6155,14'd6217,14'd6279,14'd6340,14'd6401,14'd6461,14'd6521,
        14'd6581,14'd6640,14'd6699,14'd6758,14'd6815,14'd6873,14'd6930,14'd6987,14'd7043,
        14'd7099,14'd7154,14'd7209,14'd7264,14'd7318,14'd7371,14'd7424,14'd7477,14'd7529,
        14'd7581,14'd7632,14'd7683,14'd7733,14'd7783,14'd7832,14'd7881,14'd7930,14'd7977,
        14'd8025,14'd8072,14'd8118,14'd8164,14'd8209,14'd8254,14'd8298,14'd8342,14'd8385,
        14'd8428,14'd8470,14'd8512,14'd8553,14'd8594,14'd8634,14'd8673,14'd8712,14'd8751,
        14'd8789,14'd8826,14'd8863,14'd8899,14'd8935,14'd8970,14'd9005,14'd9039,14'd9072,
        14'd9105,14'd9138,14'd9169,14'd9201,14'd9231,14'd9261,14'd9291,14'd9320,14'd9348,
        14'd9376,14'd9403,14'd9429,14'd9455,14'd9481,14'd9506,14'd9530,14'd9554,14'd9577,
        14'd9599,14'd9621,14'd9642,14'd9663,14'd9683,14'd9702,14'd9721,14'd9739,14'd9757,
        14'd9774,14'd9790,14'd9806,14'd9821,14'd9836,14'd9850,14'd9863,14'd9876,14'd9888,
        14'd9899,14'd9910,14'd9920,14'd9930,14'd9939,14'd9947,14'd9955,14'd9962,14'd9969,
        14'd9975,14'd9980,14'd9985,14'd9989,14'd9992,14'd9995,14'd9997,14'd9999,14'd10000,
        14'd10000
    };

    // atan(2^-i) as a turn fraction scaled by 2^32
    localparam logic [31:0] ATAN_TURN32 [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    // arctangent step rounded to the angle width
    function automatic angle_t atan_step(input int i);
        logic [32:0] sum;
        sum = {1'b0, ATAN_TURN32[i]} + (33'd1 << (31 - ANGLE_BITS));
        return angle_t'(sum >> (32 - ANGLE_BITS));
    endfunction

    function automatic logic [ANGLE_BITS:0] sector_base(input int k);
        return (ANGLE_BITS+1)'((longint'(k) << ANGLE_BITS) / 6);
    endfunction

    // start angle of each sector, plus the full turn
    localparam logic [ANGLE_BITS:0] SECTOR_BASE [7] = '{
        sector_base(0), sector_base(1), sector_base(2), sector_base(3),
        sector_base(4), sector_base(5), sector_base(6)
    };

endpackage

>>> hw/rtl/svpwm_front.sv
// svpwm_front: input register, squared magnitude, then a 32-stage square-root
// pipeline with the vectoring CORDIC folded into its first stages. Uses svpwm_pkg.
module svpwm_front #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [15:0]        volt_q,
    input  logic signed [15:0]        volt_d,
    input  logic [15:0]               elec_angle,
    output logic                      v_out,
    output logic [31:0]               root,
    output svpwm_pkg::svpwm_side_t    side_out
);
    import svpwm_pkg::*;

    localparam int N = SQRT_STAGES;

    // input word
    logic               v0_reg;
    logic signed [15:0] q0_reg;
    logic signed [15:0] d0_reg;
    angle_t             th0_reg;
    logic [23:0]        angle24;

    assign angle24 = {elec_angle, 8'h00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg  <= volt_q;
            d0_reg  <= volt_d;
            th0_reg <= angle24[23 -: ANGLE_BITS];
        end
    end

    // setup: magnitude squared and CORDIC start
    logic signed [31:0]         qq;
    logic signed [31:0]         dd;
    logic signed [CORDIC_W-1:0] xi;
    logic signed [CORDIC_W-1:0] yi;
    svpwm_side_t                side0_next;

    assign qq = q0_reg * q0_reg;
    assign dd = d0_reg * d0_reg;
    assign xi = {{(CORDIC_W-24){d0_reg[15]}}, d0_reg, 8'h00};
    assign yi = {{(CORDIC_W-24){q0_reg[15]}}, q0_reg, 8'h00};

    always_comb
    begin
        side0_next.simple = (d0_reg == 16'sd0);
        side0_next.neg    = q0_reg[15];
        side0_next.abs_q  = q0_reg[15] ? 16'(-q0_reg) : 16'(q0_reg);
        side0_next.theta  = th0_reg;
        side0_next.off    = '0;
    end

    logic [N:0]                 v_reg;
    logic [31:0]                mag_reg  [N+1];
    logic [33:0]                rem_reg  [N+1];
    logic [31:0]                root_reg [N+1];
    logic signed [CORDIC_W-1:0] x_reg    [N+1];
    logic signed [CORDIC_W-1:0] y_reg    [N+1];
    angle_t                     z_reg    [N+1];
    svpwm_side_t                side_reg [N+1];

    logic [33:0]                rem_next  [N];
    logic [31:0]                root_next [N];
    logic signed [CORDIC_W-1:0] x_next    [N];
    logic signed [CORDIC_W-1:0] y_next    [N];
    angle_t                     z_next    [N];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_stage
            logic [1:0]  pair;
            logic [35:0] rem_sh;
            logic [35:0] trial;
            logic        take;

            // two radicand bits per stage; the low half of the radicand is zero
            if (2 * i < 32)
            begin : g_hi
                assign pair = mag_reg[i][31-2*i -: 2];
            end
            else
            begin : g_lo
                assign pair = 2'b00;
            end

            assign rem_sh       = {rem_reg[i], pair};
            assign trial        = {2'b00, root_reg[i], 2'b01};
            assign take         = (rem_sh >= trial);
            assign rem_next[i]  = take ? 34'(rem_sh - trial) : 34'(rem_sh);
            assign root_next[i] = {root_reg[i][30:0], take};

            if (i < CORDIC_STAGES)
            begin : g_rot
                localparam angle_t STEP = atan_step(i);
                logic signed [CORDIC_W-1:0] xs;
                logic signed [CORDIC_W-1:0] ys;
                assign xs = x_reg[i] >>> i;
                assign ys = y_reg[i] >>> i;
                assign x_next[i] = y_reg[i][CORDIC_W-1] ? x_reg[i] - ys : x_reg[i] + ys;
                assign y_next[i] = y_reg[i][CORDIC_W-1] ? y_reg[i] + xs : y_reg[i] - xs;
                assign z_next[i] = y_reg[i][CORDIC_W-1] ? z_reg[i] - STEP : z_reg[i] + STEP;
            end
            else
            begin : g_hold
                assign x_next[i] = x_reg[i];
                assign y_next[i] = y_reg[i];
                assign z_next[i] = z_reg[i];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[N-1:0], v0_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0]  <= $unsigned(qq) + $unsigned(dd);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            x_reg[0]    <= d0_reg[15] ? -xi : xi;
            y_reg[0]    <= d0_reg[15] ? -yi : yi;
            z_reg[0]    <= d0_reg[15] ? HALF_TURN : '0;
            side_reg[0] <= side0_next;
            for (int k = 0; k < N; k++)
            begin
                mag_reg[k+1]  <= mag_reg[k];
                rem_reg[k+1]  <= rem_next[k];
                root_reg[k+1] <= root_next[k];
                x_reg[k+1]    <= x_next[k];
                y_reg[k+1]    <= y_next[k];
                z_reg[k+1]    <= z_next[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign v_out = v_reg[N];
    assign root  = root_reg[N];

    always_comb
    begin
        side_out     = side_reg[N];
        side_out.off = side_reg[N].simple ? QUARTER_TURN : z_reg[N];
    end

endmodule

>>> hw/rtl/svpwm_div.sv
// svpwm_div: modulation index, a 16-stage restoring divide by the supply voltage
// with saturation and the +-0.577 clamp. Uses svpwm_pkg.
module svpwm_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   v_in,
    input  logic [31:0]            root,
    input  svpwm_pkg::svpwm_side_t side_in,
    input  logic [15:0]            supply,
    output logic                   v_out,
    output svpwm_pkg::mod_t        m,
    output svpwm_pkg::svpwm_side_t side_out
);
    import svpwm_pkg::*;

    localparam int N = DIV_STAGES;

    logic [15:0] sup;
    logic [31:0] num;

    assign sup = (supply == 16'd0) ? 16'd1 : supply;
    assign num = side_in.simple ? {side_in.abs_q, 16'h0000} : root;

    logic [N:0]   v_reg;
    logic [15:0]  rem_reg  [N+1];
    logic [15:0]  lo_reg   [N+1];
    logic [15:0]  quo_reg  [N+1];
    logic [N:0]   sat_reg;
    svpwm_side_t  side_reg [N+1];

    logic [15:0]  rem_next [N];
    logic [15:0]  quo_next [N];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_stage
            logic [16:0] rs;
            logic        take;
            assign rs          = {rem_reg[i], lo_reg[i][15-i]};
            assign take        = (rs >= {1'b0, sup});
            assign rem_next[i] = take ? 16'(rs - {1'b0, sup}) : rs[15:0];
            assign quo_next[i] = {quo_reg[i][14:0], take};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[N-1:0], v_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient at or above 2^16 saturates the clamp outright
            sat_reg[0]  <= (num[31:16] >= sup);
            rem_reg[0]  <= num[31:16];
            lo_reg[0]   <= num[15:0];
            quo_reg[0]  <= '0;
            side_reg[0] <= side_in;
            for (int k = 0; k < N; k++)
            begin
                sat_reg[k+1]  <= sat_reg[k];
                rem_reg[k+1]  <= rem_next[k];
                lo_reg[k+1]   <= lo_reg[k];
                quo_reg[k+1]  <= quo_next[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // clamp and sign
    logic        vm_reg;
    mod_t        m_reg;
    svpwm_side_t sidem_reg;
    logic [16:0] mag_next;

    always_comb
    begin
        if (sat_reg[N] || (quo_reg[N] > 16'(MOD_LIMIT)))
            mag_next = 17'(MOD_LIMIT);
        else
            mag_next = {1'b0, quo_reg[N]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else if (en)
            vm_reg <= v_reg[N];
    end

    // only the simple path carries a sign; the vector magnitude is never negative
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg     <= (side_reg[N].simple && side_reg[N].neg) ?
                         -$signed(mag_next) : $signed(mag_next);
            sidem_reg <= side_reg[N];
        end
    end

    assign v_out    = vm_reg;
    assign m        = m_reg;
    assign side_out = sidem_reg;

endmodule

>>> hw/rtl/svpwm_dwell.sv
// svpwm_dwell: sector, sine lookups, dwell times and phase duties over eleven stages;
// the last stage is the output register. Uses svpwm_pkg.
module svpwm_dwell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   v_in,
    input  svpwm_pkg::mod_t        m,
    input  svpwm_pkg::svpwm_side_t side_in,
    input  logic [15:0]            full_scale,
    output logic                   v_out,
    output logic [15:0]            duty_a,
    output logic [15:0]            duty_b,
    output logic [15:0]            duty_c,
    output logic [2:0]             sector_num
);
    import svpwm_pkg::*;

    localparam int ST = 11;

    logic [ST-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[ST-2:0], v_in};
    end

    // s1: rotated angle and sector
    angle_t              theta_next;
    logic [ANGLE_BITS+2:0] prod6;
    angle_t              th1_reg;
    logic [2:0]          sec1_reg;
    mod_t                m1_reg;

    assign theta_next = side_in.theta + side_in.off;
    assign prod6      = {3'b000, theta_next} * (ANGLE_BITS+3)'(6);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th1_reg  <= theta_next;
            sec1_reg <= prod6[ANGLE_BITS+2:ANGLE_BITS];
            m1_reg   <= m;
        end
    end

    // s2: sine indexes
    logic [ANGLE_BITS:0]   u1;
    logic [ANGLE_BITS:0]   u2;
    logic [39:0]           t1s;
    logic [39:0]           t2s;
    logic [39:0]           i1f;
    logic [39:0]           i2f;
    logic [SINE_IDX_W-1:0] idx1_reg;
    logic [SINE_IDX_W-1:0] idx2_reg;
    logic [2:0]            sec2_reg;
    mod_t                  m2_reg;

    assign u1  = SECTOR_BASE[sec1_reg + 3'd1] - {1'b0, th1_reg};
    assign u2  = {1'b0, th1_reg} - SECTOR_BASE[sec1_reg];
    assign t1s = 40'(u1) * 40'(SINE_IDX_MUL) + (40'd1 << (ANGLE_BITS - 1));
    assign t2s = 40'(u2) * 40'(SINE_IDX_MUL) + (40'd1 << (ANGLE_BITS - 1));
    assign i1f = t1s >> ANGLE_BITS;
    assign i2f = t2s >> ANGLE_BITS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg <= (i1f > 40'(SINE_TABLE_DEPTH - 1)) ?
                        SINE_IDX_W'(SINE_TABLE_DEPTH - 1) : i1f[SINE_IDX_W-1:0];
            idx2_reg <= (i2f > 40'(SINE_TABLE_DEPTH - 1)) ?
                        SINE_IDX_W'(SINE_TABLE_DEPTH - 1) : i2f[SINE_IDX_W-1:0];
            sec2_reg <= sec1_reg;
            m2_reg   <= m1_reg;
        end
    end

    // s3: table reads
    logic [13:0] sin1_reg;
    logic [13:0] sin2_reg;
    logic [2:0]  sec3_reg;
    mod_t        m3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin1_reg <= QUARTER_SINE[idx1_reg];
            sin2_reg <= QUARTER_SINE[idx2_reg];
            sec3_reg <= sec2_reg;
            m3_reg   <= m2_reg;
        end
    end

    // s4: sqrt(3) * sin
    logic [30:0] p1_reg;
    logic [30:0] p2_reg;
    logic [2:0]  sec4_reg;
    mod_t        m4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= 31'(sin1_reg) * 31'(SQRT3_Q16);
            p2_reg   <= 31'(sin2_reg) * 31'(SQRT3_Q16);
            sec4_reg <= sec3_reg;
            m4_reg   <= m3_reg;
        end
    end

    // s5: times modulation
    logic signed [47:0] x1_reg;
    logic signed [47:0] x2_reg;
    logic [2:0]         sec5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= 48'($signed({1'b0, p1_reg})) * 48'(m4_reg);
            x2_reg   <= 48'($signed({1'b0, p2_reg})) * 48'(m4_reg);
            sec5_reg <= sec4_reg;
        end
    end

    // s6: magnitude >> 16, reciprocal multiply for / 10000
    logic [47:0] ax1;
    logic [47:0] ax2;
    logic [29:0] y1_reg;
    logic [29:0] y2_reg;
    logic [56:0] yr1_reg;
    logic [56:0] yr2_reg;
    logic        n1_reg;
    logic        n2_reg;
    logic [2:0]  sec6_reg;

    assign ax1 = x1_reg[47] ? 48'(-x1_reg) : 48'(x1_reg);
    assign ax2 = x2_reg[47] ? 48'(-x2_reg) : 48'(x2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg   <= ax1[45:16];
            y2_reg   <= ax2[45:16];
            yr1_reg  <= 57'(ax1[45:16]) * 57'(RECIP_SINE);
            yr2_reg  <= 57'(ax2[45:16]) * 57'(RECIP_SINE);
            n1_reg   <= x1_reg[47];
            n2_reg   <= x2_reg[47];
            sec6_reg <= sec5_reg;
        end
    end

    // s7: quotient estimate, low by at most one
    logic [30:0] r1;
    logic [30:0] r2;
    logic [16:0] q1_reg;
    logic [16:0] q2_reg;
    logic        c1_reg;
    logic        c2_reg;
    logic        n1b_reg;
    logic        n2b_reg;
    logic [2:0]  sec7_reg;

    assign r1 = {1'b0, y1_reg} - 31'(31'(yr1_reg[56:40]) * 31'(SINE_SCALE));
    assign r2 = {1'b0, y2_reg} - 31'(31'(yr2_reg[56:40]) * 31'(SINE_SCALE));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg   <= yr1_reg[56:40];
            q2_reg   <= yr2_reg[56:40];
            c1_reg   <= (r1 >= 31'(SINE_SCALE));
            c2_reg   <= (r2 >= 31'(SINE_SCALE));
            n1b_reg  <= n1_reg;
            n2b_reg  <= n2_reg;
            sec7_reg <= sec6_reg;
        end
    end

    // s8: correct and restore sign
    logic [16:0]        tm1;
    logic [16:0]        tm2;
    logic signed [17:0] t1_reg;
    logic signed [17:0] t2_reg;
    logic [2:0]         sec8_reg;

    assign tm1 = q1_reg + 17'(c1_reg);
    assign tm2 = q2_reg + 17'(c2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg   <= n1b_reg ? -$signed({1'b0, tm1}) : $signed({1'b0, tm1});
            t2_reg   <= n2b_reg ? -$signed({1'b0, tm2}) : $signed({1'b0, tm2});
            sec8_reg <= sec7_reg;
        end
    end

    // s9: zero-vector half time and phase sums
    logic signed [19:0] e1;
    logic signed [19:0] e2;
    logic signed [19:0] tz;
    logic signed [19:0] th;
    logic signed [19:0] ta_next;
    logic signed [19:0] tb_next;
    logic signed [19:0] tc_next;
    logic signed [19:0] ta_reg;
    logic signed [19:0] tb_reg;
    logic signed [19:0] tc_reg;
    logic [2:0]         sec9_reg;

    assign e1 = 20'(t1_reg);
    assign e2 = 20'(t2_reg);
    assign tz = 20'sd65536 - e1 - e2;
    assign th = (tz + $signed({19'd0, tz[19]})) >>> 1;

    always_comb
    begin
        case (sec8_reg)
            3'd0:
            begin
                ta_next = e1 + e2 + th; tb_next = e2 + th;      tc_next = th;
            end
            3'd1:
            begin
                ta_next = e1 + th;      tb_next = e1 + e2 + th; tc_next = th;
            end
            3'd2:
            begin
                ta_next = th;           tb_next = e1 + e2 + th; tc_next = e2 + th;
            end
            3'd3:
            begin
                ta_next = th;           tb_next = e1 + th;      tc_next = e1 + e2 + th;
            end
            3'd4:
            begin
                ta_next = e2 + th;      tb_next = th;           tc_next = e1 + e2 + th;
            end
            default:
            begin
                ta_next = e1 + e2 + th; tb_next = th;           tc_next = e1 + th;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta_reg   <= ta_next;
            tb_reg   <= tb_next;
            tc_reg   <= tc_next;
            sec9_reg <= sec8_reg;
        end
    end

    // s10: scale by full scale
    logic [34:0] pa_reg;
    logic [34:0] pb_reg;
    logic [34:0] pc_reg;
    logic        pos_a_reg;
    logic        pos_b_reg;
    logic        pos_c_reg;
    logic [2:0]  sec10_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg    <= 35'(ta_reg[18:0]) * 35'(full_scale);
            pb_reg    <= 35'(tb_reg[18:0]) * 35'(full_scale);
            pc_reg    <= 35'(tc_reg[18:0]) * 35'(full_scale);
            pos_a_reg <= !ta_reg[19] && (ta_reg != 20'sd0);
            pos_b_reg <= !tb_reg[19] && (tb_reg != 20'sd0);
            pos_c_reg <= !tc_reg[19] && (tc_reg != 20'sd0);
            sec10_reg <= sec9_reg;
        end
    end

    // s11: saturate, output register
    logic [15:0] da_next;
    logic [15:0] db_next;
    logic [15:0] dc_next;
    logic [15:0] da_reg;
    logic [15:0] db_reg;
    logic [15:0] dc_reg;
    logic [2:0]  sec_out_reg;

    assign da_next = !pos_a_reg ? 16'd0 :
                     (pa_reg[34:16] > {3'b000, full_scale}) ? full_scale : pa_reg[31:16];
    assign db_next = !pos_b_reg ? 16'd0 :
                     (pb_reg[34:16] > {3'b000, full_scale}) ? full_scale : pb_reg[31:16];
    assign dc_next = !pos_c_reg ? 16'd0 :
                     (pc_reg[34:16] > {3'b000, full_scale}) ? full_scale : pc_reg[31:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            da_reg      <= da_next;
            db_reg      <= db_next;
            dc_reg      <= dc_next;
            sec_out_reg <= sec10_reg + 3'd1;
        end
    end

    assign v_out      = v_reg[ST-1];
    assign duty_a     = da_reg;
    assign duty_b     = db_reg;
    assign duty_c     = dc_reg;
    assign sector_num = sec_out_reg;

endmodule

>>> hw/rtl/space_vector_pwm_duty_generator.sv
// space_vector_pwm_duty_generator: top level of the SVPWM duty generator.
// Holds the configuration registers and chains svpwm_front, svpwm_div, svpwm_dwell.
//
// Channel   Direction  Handshake            Word
// in        input      in_valid/in_ready    volt_q, volt_d, elec_angle
// out       output     out_valid/out_ready  duty_a, duty_b, duty_c, sector_num
// cfg       input      cfg_wr_en            cfg_index, cfg_wdata (no read-back)
//
// Throughput is one word per clock while the output word is not held. The front
// end has the input register, squaring, and one square-root bit per stage with
// the CORDIC in the first CORDIC_STAGES of them; the divider has one quotient bit
// per stage; the dwell/duty path ends at the output register.
// The whole pipeline advances as one: a held output word freezes every stage,
// so a stall drops and repeats nothing. Reset clears the valid bits and
// loads supply_voltage = 3072 and pwm_full_scale = 1000.
module space_vector_pwm_duty_generator #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] volt_q,
    input  logic signed [15:0] volt_d,
    input  logic [15:0]        elec_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        duty_a,
    output logic [15:0]        duty_b,
    output logic [15:0]        duty_c,
    output logic [2:0]         sector_num,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_wdata
);
    import svpwm_pkg::*;

    // configuration registers
    logic [15:0] supply_reg;
    logic [15:0] full_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg     <= 16'd3072;
            full_scale_reg <= 16'd1000;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SUPPLY:     supply_reg     <= cfg_wdata;
                REG_FULL_SCALE: full_scale_reg <= cfg_wdata;
            endcase
        end
    end

    // one pipeline enable for every stage: advance unless the output word is held
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    logic        fv;
    logic [31:0] root;
    svpwm_side_t fside;
    logic        dv;
    mod_t        m;
    svpwm_side_t dside;

    svpwm_front #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .volt_q     (volt_q),
        .volt_d     (volt_d),
        .elec_angle (elec_angle),
        .v_out      (fv),
        .root       (root),
        .side_out   (fside)
    );

    svpwm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .v_in     (fv),
        .root     (root),
        .side_in  (fside),
        .supply   (supply_reg),
        .v_out    (dv),
        .m        (m),
        .side_out (dside)
    );

    svpwm_dwell u_dwell (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .v_in       (dv),
        .m          (m),
        .side_in    (dside),
        .full_scale (full_scale_reg),
        .v_out      (out_valid),
        .duty_a     (duty_a),
        .duty_b     (duty_b),
        .duty_c     (duty_c),
        .sector_num (sector_num)
    );

    // a valid word always carries a real sector
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sector_num >= 3'd1 && sector_num <= 3'd6))
        else $error("sector out of range");

    // input only stalls behind a held output word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output back-pressure");

    // the divider feeds the dwell path only in its clamp range
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv |-> (m <= 17'sd37814 && m >= -17'sd37814))
        else $error("modulation out of clamp range");

endmodule

>>> bench/testbench.sv
// testbench: self-checking bench for the SVPWM duty generator.
// Depends on svpwm_pkg and space_vector_pwm_duty_generator, which needs svpwm_front, svpwm_div and svpwm_dwell.
`timescale 1ns / 100ps

module testbench;
    import svpwm_pkg::*;

    typedef struct {
        logic [15:0] da;
        logic [15:0] db;
        logic [15:0] dc;
        logic [2:0]  sec;
    } duty_word_t;

    // directed row: known marks a row with a typed-in answer
    typedef struct {
        logic [15:0] q;
        logic [15:0] d;
        logic [15:0] ang;
        bit          known;
        duty_word_t  ans;
    } vec_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic signed [15:0] volt_q = '0;
    logic signed [15:0] volt_d = '0;
    logic [15:0] elec_angle = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] duty_a, duty_b, duty_c;
    logic [2:0]  sector_num;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = REG_SUPPLY;
    logic [15:0] cfg_wdata = '0;

    // bench copy of the two registers
    longint      supply_v = 3072;
    longint      full_scale = 1000;

    duty_word_t  pending_duties[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    space_vector_pwm_duty_generator dut (.*);

    always #5 clk = ~clk;

    function automatic longint floor_shr(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v - 1) >>> s) - 1;
    endfunction

    function automatic longint isqrt_u64(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // vectoring CORDIC giving atan2(q, d) as a 16-bit turn fraction
    function automatic longint phase_of(longint y, longint x);
        longint z, stepv, xs, ys;
        z = 0;
        x = x * 256;
        y = y * 256;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32768;
        end
        for (int i = 0; i < 16; i++)
        begin
            stepv = (longint'(ATAN_TURN32[i]) + 32768) >> 16;
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += stepv;
            end
            else
            begin
                x -= ys; y += xs; z -= stepv;
            end
        end
        return z;
    endfunction

    function automatic longint sine_q(longint u);
        longint idx;
        if (u < 0)
            u = 0;
        idx = (u * 4 * 199 + 32768) >> 16;
        if (idx > 199)
            idx = 199;
        return longint'(QUARTER_SINE[idx]);
    endfunction

    function automatic logic [15:0] duty_of(longint t);
        longint v;
        if (t <= 0)
            return '0;
        v = (t * full_scale) >> 16;
        return 16'(v > full_scale ? full_scale : v);
    endfunction

    function automatic duty_word_t svpwm_duties(logic [15:0] q16, logic [15:0] d16,
                                                logic [15:0] ang);
        longint q, d, sup, m, off, th, s0, t1, t2, th0, ta, tb, tc;
        duty_word_t r;
        q = longint'(signed'(q16));
        d = longint'(signed'(d16));
        sup = (supply_v == 0) ? 1 : supply_v;
        if (d == 0)
        begin
            m = (q * 65536) / sup;
            off = 16384;
        end
        else
        begin
            m = isqrt_u64(longint'(d * d + q * q) << 32) / sup;
            off = phase_of(q, d);
        end
        if (m > MOD_LIMIT) m = MOD_LIMIT;
        if (m < -MOD_LIMIT) m = -MOD_LIMIT;
        th = (longint'(ang) + off) & 65535;
        s0 = (th * 6) >> 16;
        if (s0 > 5) s0 = 5;
        t1 = (SQRT3_Q16 * sine_q(((s0 + 1) * 65536) / 6 - th) * m) / (64'sd10000 * 65536);
        t2 = (SQRT3_Q16 * sine_q(th - (s0 * 65536) / 6) * m) / (64'sd10000 * 65536);
        th0 = (65536 - t1 - t2) / 2;
        case (s0)
            0: begin ta = t1 + t2 + th0; tb = t2 + th0; tc = th0; end
            1: begin ta = t1 + th0; tb = t1 + t2 + th0; tc = th0; end
            2: begin ta = th0; tb = t1 + t2 + th0; tc = t2 + th0; end
            3: begin ta = th0; tb = t1 + th0; tc = t1 + t2 + th0; end
            4: begin ta = t2 + th0; tb = th0; tc = t1 + t2 + th0; end
            default: begin ta = t1 + t2 + th0; tb = th0; tc = t1 + th0; end
        endcase
        r.da = duty_of(ta);
        r.db = duty_of(tb);
        r.dc = duty_of(tc);
        r.sec = 3'(s0 + 1);
        return r;
    endfunction

    // drive one word and hold it until accepted; optional sender gap first
    task automatic send_word(logic [15:0] q, logic [15:0] d, logic [15:0] ang,
                             duty_word_t ans);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        volt_q <= q;
        volt_d <= d;
        elec_angle <= ang;
        pending_duties.push_back(ans);
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_checked(logic [15:0] q, logic [15:0] d, logic [15:0] ang);
        send_word(q, d, ang, svpwm_duties(q, d, ang));
    endtask

    // wait for the pipe to drain, then for its latency before touching registers
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_duties.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        if (idx == REG_SUPPLY)
            supply_v = val;
        else
            full_scale = val;
    endtask

    // mostly modest commands so the clamp does not hide the dwell math
    task automatic send_random();
        logic [15:0] q, d;
        case ($urandom_range(9))
            0: begin q = 16'($urandom); d = '0; end
            1: begin q = 16'($urandom); d = 16'($urandom); end
            2: begin q = 16'($signed($urandom_range(0, 1600)) - 800); d = '0; end
            default:
            begin
                q = 16'($signed($urandom_range(0, 1600)) - 800);
                d = 16'($signed($urandom_range(0, 1600)) - 800);
            end
        endcase
        send_checked(q, d, 16'($urandom));
    endtask

    // receiver: random stalls, compare with oldest expectation
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_duties.size() == 0)
            begin
                $error("unexpected word: duty_a %0d", duty_a);
                errors++;
            end
            else
            begin
                duty_word_t e;
                e = pending_duties.pop_front();
                if (duty_a !== e.da)
                begin
                    $error("duty_a expected %0d got %0d", e.da, duty_a); errors++;
                end
                if (duty_b !== e.db)
                begin
                    $error("duty_b expected %0d got %0d", e.db, duty_b); errors++;
                end
                if (duty_c !== e.dc)
                begin
                    $error("duty_c expected %0d got %0d", e.dc, duty_c); errors++;
                end
                if (sector_num !== e.sec)
                begin
                    $error("sector_num expected %0d got %0d", e.sec, sector_num); errors++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        vec_row_t rows[$];
        vec_row_t r;
        duty_word_t z500;
        z500 = '{da: 16'd500, db: 16'd500, dc: 16'd500, sec: 3'd2};

        // directed table; zero command at reset scale gives 500 on every phase
        rows.push_back('{16'h0000, 16'h0000, 16'h0000, 1'b1, z500});
        rows.push_back('{16'h7FFF, 16'h0000, 16'h0000, 1'b0, z500});
        rows.push_back('{16'h8000, 16'h0000, 16'hFFFF, 1'b0, z500});
        rows.push_back('{16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, z500});
        rows.push_back('{16'h8000, 16'h8000, 16'h4000, 1'b0, z500});
        rows.push_back('{16'h0000, 16'h8000, 16'h0001, 1'b0, z500});
        rows.push_back('{16'h0000, 16'h7FFF, 16'h2AAA, 1'b0, z500});
        rows.push_back('{16'hFC00, 16'h0000, 16'h5555, 1'b0, z500});
        rows.push_back('{16'h0100, 16'hFF00, 16'hAAAA, 1'b0, z500});
        rows.push_back('{16'hFF00, 16'h0100, 16'hD555, 1'b0, z500});
        for (int k = 0; k < 6; k++)
            rows.push_back('{16'h0200, 16'h0000, 16'(k * 10923 + 5000), 1'b0, z500});

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            r = rows[i];
            if (r.known)
                send_word(r.q, r.d, r.ang, r.ans);
            else
                send_checked(r.q, r.d, r.ang);
        end
        drain_pipe();

        // zero supply and zero full scale, then extremes
        write_reg(REG_SUPPLY, 16'd0);
        write_reg(REG_FULL_SCALE, 16'd0);
        send_word(16'h0123, 16'h0000, 16'h1234, '{16'd0, 16'd0, 16'd0, 3'd2});
        send_checked(16'hFEDC, 16'h0040, 16'h9000);
        drain_pipe();
        write_reg(REG_SUPPLY, 16'hFFFF);
        write_reg(REG_FULL_SCALE, 16'hFFFF);
        send_checked(16'h7FFF, 16'h0000, 16'h3000);
        send_checked(16'h8000, 16'h7FFF, 16'hC000);
        drain_pipe();

        // random: three idling phases, registers changed between them
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 59 : 0;
            recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 27 : 0;
            write_reg(REG_SUPPLY, (ph == 2) ? 16'd1 : 16'($urandom_range(256, 8192)));
            write_reg(REG_FULL_SCALE, (ph == 2) ? 16'd1 : 16'($urandom_range(1, 65535)));
            for (int n = 0; n < 200; n++)
            begin
                send_random();
                if (n == 100)
                begin
                    // hold off until everything in flight has come back
                    in_valid <= 1'b0;
                    while (pending_duties.size() != 0)
                        @(negedge clk);
                end
            end
            drain_pipe();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/svpwm_pkg.sv
hw/rtl/svpwm_front.sv
hw/rtl/svpwm_div.sv
hw/rtl/svpwm_dwell.sv
hw/rtl/space_vector_pwm_duty_generator.sv
bench/testbench.sv
